@@ rtl/linear_probe_hash_map_core_defines.svh @@
// Assertion macros for the hash map core checker.
`ifndef LINEAR_PROBE_HASH_MAP_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LPHM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define LPHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ rtl/lphm_pkg.sv @@
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types, codes and constants of the linear probing hash map core.
// ----------------------------------------------------------------------------
package lphm_pkg;
	localparam int unsigned SLOTS_DEF = 1024;
	localparam int unsigned LIMIT_W = 11;
	localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 11'd640;

	localparam logic [1:0] CMD_GET = 2'd0;
	localparam logic [1:0] CMD_SET = 2'd1;
	localparam logic [1:0] CMD_DEL = 2'd2;

	localparam logic [2:0] ST_FOUND = 3'd0;
	localparam logic [2:0] ST_MISS = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_UPDATED = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture request, reset probe
		logic rd;       // issue memory read at probe index
		logic eval;     // evaluate returned slot
		logic commit;   // apply write and produce result
		logic clr;      // clear pass write
	} lphm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;      // probe finished
		logic clr_last;  // last entry of clear pass
	} lphm_sts_t;
endpackage

@@ rtl/lphm_ctrl.sv @@
// ----------------------------------------------------------------------------
// lphm_ctrl
// Sequencer: clear pass, then read / evaluate loop per probe, then commit.
// ----------------------------------------------------------------------------
module lphm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output lphm_pkg::lphm_cmd_t cmd_o,
	input  lphm_pkg::lphm_sts_t sts_i
);
	import lphm_pkg::*;

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			unique case (state_q)
				S_CLR: if (sts_i.clr_last) state_q <= S_IDLE;
				S_IDLE: if (start) state_q <= S_RD;
				S_RD: state_q <= S_EVAL;
				S_EVAL: state_q <= sts_i.done ? S_COMMIT : S_EVAL;
				S_COMMIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd_o = '0;
		cmd_o.clr = (state_q == S_CLR);
		cmd_o.load = (state_q == S_IDLE) && start;
		cmd_o.rd = (state_q == S_RD) || ((state_q == S_EVAL) && !sts_i.done);
		cmd_o.eval = (state_q == S_EVAL);
		cmd_o.commit = (state_q == S_COMMIT);
	end

	assign busy = (state_q != S_IDLE);
endmodule

@@ rtl/lphm_dp.sv @@
// ----------------------------------------------------------------------------
// lphm_dp
// Slot memories, probe index and counters, match logic and result registers.
// ----------------------------------------------------------------------------
module lphm_dp #(
	parameter int unsigned SLOTS = lphm_pkg::SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  lphm_pkg::lphm_cmd_t cmd_i,
	output lphm_pkg::lphm_sts_t sts_o,
	input  logic [1:0] cmd,
	input  logic [63:0] key,
	input  logic [31:0] key_hash,
	input  logic [63:0] new_value,
	input  logic [lphm_pkg::LIMIT_W-1:0] load_limit,
	output logic done,
	output logic [2:0] status,
	output logic [63:0] read_value
);
	import lphm_pkg::*;

	localparam int unsigned AW = $clog2(SLOTS);
	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] PROBE_LAST = CW'(SLOTS - 1);

	// memories; key/value undefined until written, flags cleared by sweep
	logic [63:0] key_mem [SLOTS];
	logic [63:0] val_mem [SLOTS];
	logic [1:0]  flg_mem [SLOTS]; // {live, tomb}

	logic [63:0] rkey_q, rval_q;
	logic [1:0]  rflg_q;
	logic [AW-1:0] ridx_q;

	logic [1:0]  cmd_q;
	logic [63:0] key_q, nval_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic has_tomb_q;
	logic [AW-1:0] tomb_q;
	logic hit_q, empty_q;
	logic [AW-1:0] at_q;
	logic [LIMIT_W-1:0] fill_q;
	logic [AW-1:0] clr_q;

	// probe evaluation of returned slot
	logic live, tomb, match, stop_hit, stop_empty, last, fin;
	assign live = rflg_q[1];
	assign tomb = rflg_q[0];
	assign match = live && (rkey_q == key_q);
	assign stop_hit = cmd_i.eval && match;
	assign stop_empty = cmd_i.eval && !live && !tomb;
	assign last = (n_q == PROBE_LAST);
	assign fin = stop_hit || stop_empty || (cmd_i.eval && last);
	assign sts_o.done = fin;
	assign sts_o.clr_last = (clr_q == AW'(SLOTS - 1));

	// next probe index; rd during eval advances
	logic [AW-1:0] idx_nx;
	assign idx_nx = (idx_q == AW'(SLOTS - 1)) ? '0 : idx_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			fill_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd_i.commit;
			if (cmd_i.clr) clr_q <= clr_q + 1'b1;
			if (cmd_i.commit && cmd_q == CMD_SET && !hit_q && !has_tomb_q && empty_q
			    && fill_q < load_limit)
				fill_q <= fill_q + 1'b1;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (cmd_i.rd) begin
			rkey_q <= key_mem[idx_q];
			rval_q <= val_mem[idx_q];
			rflg_q <= flg_mem[idx_q];
			ridx_q <= idx_q;
		end
	end

	// probe registers
	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			cmd_q <= cmd;
			key_q <= key;
			nval_q <= new_value;
			idx_q <= key_hash[AW-1:0];
			n_q <= '0;
			has_tomb_q <= 1'b0;
			hit_q <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			if (cmd_i.rd) idx_q <= idx_nx;
			if (cmd_i.eval) begin
				if (!fin) n_q <= n_q + 1'b1;
				if (!live && tomb && !has_tomb_q) begin
					has_tomb_q <= 1'b1;
					tomb_q <= ridx_q;
				end
				hit_q <= match;
				empty_q <= stop_empty;
				at_q <= ridx_q;
			end
		end
	end

	// single write port: clear sweep or commit
	logic we;
	logic [AW-1:0] wa;
	logic [1:0] wf;
	logic wkv, wv;
	always_comb begin
		we = 1'b0; wa = at_q; wf = 2'b10; wkv = 1'b0; wv = 1'b0;
		status = ST_MISS;
		if (cmd_i.clr) begin
			we = 1'b1; wa = clr_q; wf = 2'b00;
		end else if (cmd_i.commit) begin
			unique case (cmd_q)
				CMD_GET: if (hit_q) status = ST_FOUND;
				CMD_DEL: if (hit_q) begin
					status = ST_FOUND; we = 1'b1; wf = 2'b01;
				end
				CMD_SET: if (hit_q) begin
					status = ST_UPDATED; wv = 1'b1;
				end else if (has_tomb_q) begin
					status = ST_INSERTED; we = 1'b1; wa = tomb_q; wkv = 1'b1;
				end else if (empty_q && fill_q < load_limit) begin
					status = ST_INSERTED; we = 1'b1; wkv = 1'b1;
				end else begin
					status = ST_FULL;
				end
				default: status = ST_MISS;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) flg_mem[wa] <= wf;
		if (wkv) key_mem[wa] <= key_q;
		if (wkv || wv) val_mem[wa] <= nval_q;
	end

	logic [63:0] rv_q;
	always_ff @(posedge clk) begin
		if (cmd_i.commit) begin
			rv_q <= ((cmd_q == CMD_GET || cmd_q == CMD_DEL) && hit_q) ? rval_q : '0;
		end
	end
	assign read_value = rv_q;
endmodule

@@ rtl/linear_probe_hash_map_core.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_map_core
// Open-addressing key/value map with linear probing and tombstones.
// ----------------------------------------------------------------------------
// After reset the core sweeps all SLOTS entries of the slot flag memory
// once with busy high, then accepts a transfer when start is high and busy
// is low. Each operation probes P slots (1 to SLOTS) before the done
// strobe: the single memory read port yields one slot per cycle. The
// result sits on status and read_value for exactly one cycle with done
// high; the receiver cannot stall it, so capture it then. Write load_limit
// only while busy is low.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_core #(
	parameter int unsigned SLOTS = lphm_pkg::SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] cmd,
	input  logic [63:0] key,
	input  logic [31:0] key_hash,
	input  logic [63:0] new_value,
	input  logic cfg_we,
	input  logic [lphm_pkg::LIMIT_W-1:0] cfg_wdata,
	output logic done,
	output logic [2:0] status,
	output logic [63:0] read_value
);
	import lphm_pkg::*;

	lphm_cmd_t c;
	lphm_sts_t s;
	logic [LIMIT_W-1:0] load_limit_q;
	logic [2:0] st_comb;
	logic [2:0] status_q;

	// hold the load limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) load_limit_q <= LOAD_LIMIT_RST;
		else if (cfg_we) load_limit_q <= cfg_wdata;
	end

	lphm_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd_o(c), .sts_i(s));

	lphm_dp #(.SLOTS(SLOTS)) u_dp (
		.clk, .arst_n, .cmd_i(c), .sts_o(s), .cmd, .key, .key_hash,
		.new_value, .load_limit(load_limit_q), .done, .status(st_comb), .read_value
	);

	// register status alongside the value
	always_ff @(posedge clk) begin
		if (c.commit) status_q <= st_comb;
	end
	assign status = status_q;
endmodule

@@ rtl/lphm_checker.sv @@
// ----------------------------------------------------------------------------
// lphm_checker
// Port-level checks of the hash map core handshake and results.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_map_core_defines.svh"
module lphm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [2:0] status,
	input logic [63:0] read_value
);
	import lphm_pkg::*;

	`LPHM_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`LPHM_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`LPHM_ASSERT_IMPL(a_status_range, clk, arst_n, done, status <= ST_FULL)
	`LPHM_ASSERT_IMPL(a_zero_value, clk, arst_n, done && status != ST_FOUND, read_value == 64'd0)
endmodule

bind linear_probe_hash_map_core lphm_checker u_chk (.clk, .arst_n, .start, .busy, .done,
	.status, .read_value);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear probing hash map core: directed table,
// then random get/set/delete traffic over several load limits, a full-table
// sweep, and a scoreboard fed by a cycle-free model of the slot memory.
// ----------------------------------------------------------------------------
module tb;
	import lphm_pkg::*;

	localparam int unsigned NSLOT = 1024;
	localparam logic [1:0] CMD_UNDEF = 2'd3;
	localparam int N_DIR = 21;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		logic [2:0]  st;
		logic [63:0] rv;
	} reply_t;

	typedef struct {
		logic [1:0]  c;
		logic [63:0] k;
		logic [31:0] h;
		logic [63:0] v;
		bit          typed;   // expected reply written into the row
		logic [2:0]  st;
		logic [63:0] rv;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] cmd = '0;
	logic [63:0] key = '0;
	logic [31:0] key_hash = '0;
	logic [63:0] new_value = '0;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;
	logic busy;
	logic done;
	logic [2:0] status;
	logic [63:0] read_value;

	// shadow copy of the map
	logic [63:0] map_key [NSLOT];
	logic [63:0] map_val [NSLOT];
	bit map_live [NSLOT];
	bit map_tomb [NSLOT];
	int unsigned map_fill;
	int unsigned map_limit;

	reply_t pending_replies [$];
	int unsigned n_err = 0;
	int unsigned n_shown = 0;

	logic [63:0] pool_key [32];
	logic [31:0] pool_hash [32];
	dir_row_t dir_tab [N_DIR];
	bit idle_on = 1'b1;

	linear_probe_hash_map_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .key(key), .key_hash(key_hash), .new_value(new_value),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .status(status), .read_value(read_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Walk the probe chain and apply the operation to the shadow map.
	task automatic map_apply(input logic [1:0] c, input logic [63:0] k,
			input logic [31:0] h, input logic [63:0] v, output reply_t r);
		int unsigned idx;
		int unsigned n;
		bit hit, has_tomb, has_empty;
		int unsigned hit_at, tomb_at, empty_at;
		idx = h % NSLOT;
		hit = 0; has_tomb = 0; has_empty = 0;
		hit_at = 0; tomb_at = 0; empty_at = 0;
		r.st = ST_MISS;
		r.rv = '0;
		if (c != CMD_UNDEF) begin
			for (n = 0; n < NSLOT; n++) begin
				if (map_live[idx]) begin
					if (map_key[idx] == k) begin
						hit = 1; hit_at = idx;
						break;
					end
				end else if (map_tomb[idx]) begin
					if (!has_tomb) begin
						has_tomb = 1; tomb_at = idx;
					end
				end else begin
					has_empty = 1; empty_at = idx;
					break;
				end
				idx = (idx + 1) % NSLOT;
			end
			case (c)
				CMD_GET: begin
					if (hit) begin
						r.st = ST_FOUND;
						r.rv = map_val[hit_at];
					end
				end
				CMD_DEL: begin
					if (hit) begin
						r.st = ST_FOUND;
						r.rv = map_val[hit_at];
						map_live[hit_at] = 0;
						map_tomb[hit_at] = 1;
					end
				end
				default: begin
					if (hit) begin
						map_val[hit_at] = v;
						r.st = ST_UPDATED;
					end else if (has_tomb) begin
						// reuse the first tombstone; fill count stays
						map_tomb[tomb_at] = 0;
						map_live[tomb_at] = 1;
						map_key[tomb_at] = k;
						map_val[tomb_at] = v;
						r.st = ST_INSERTED;
					end else if (has_empty && map_fill < map_limit) begin
						map_live[empty_at] = 1;
						map_key[empty_at] = k;
						map_val[empty_at] = v;
						map_fill++;
						r.st = ST_INSERTED;
					end else begin
						r.st = ST_FULL;
					end
				end
			endcase
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one transfer and hold it until the core takes it.
	task automatic send_op(input logic [1:0] c, input logic [63:0] k,
			input logic [31:0] h, input logic [63:0] v,
			input bit typed, input reply_t fixed);
		int unsigned gap;
		reply_t r;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		key <= k;
		key_hash <= h;
		new_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		// accepted at this edge: advance the shadow map
		map_apply(c, k, h, v, r);
		pending_replies.push_back(typed ? fixed : r);
	endtask

	task automatic send_pred(input logic [1:0] c, input logic [63:0] k,
			input logic [31:0] h, input logic [63:0] v);
		reply_t none;
		none.st = ST_MISS;
		none.rv = '0;
		send_op(c, k, h, v, 1'b0, none);
	endtask

	// Drain outstanding replies, then write the load limit while idle.
	task automatic write_limit(input logic [LIMIT_W-1:0] lim);
		start <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0 || busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		map_limit = lim;
	endtask

	task automatic random_ops(input int n);
		int i;
		int unsigned r;
		int unsigned p;
		logic [1:0] c;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			p = $urandom_range(0, 31);
			if (r < 40) c = CMD_SET;
			else if (r < 70) c = CMD_GET;
			else if (r < 92) c = CMD_DEL;
			else if (r < 96) c = CMD_UNDEF;
			else c = CMD_SET;
			if (r >= 96) begin
				// noise: fresh key and unrelated hash
				send_pred(c, {$urandom, $urandom}, $urandom, {$urandom, $urandom});
			end else begin
				send_pred(c, pool_key[p], pool_hash[p], {$urandom, $urandom});
			end
		end
	endtask

	// Scoreboard: each done strobe pairs with the oldest expectation.
	always @(posedge clk) begin
		reply_t e;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				n_err++;
				if (n_shown < MAX_SHOWN) begin
					n_shown++;
					$display("unexpected result: status %0d value %h", status, read_value);
				end
			end else begin
				e = pending_replies.pop_front();
				if (status !== e.st || read_value !== e.rv) begin
					n_err++;
					if (n_shown < MAX_SHOWN) begin
						n_shown++;
						$display("mismatch: status exp %0d got %0d, value exp %h got %h",
							e.st, status, e.rv, read_value);
					end
				end
			end
		end
	end

	initial begin
		#40000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int i;
		int wait_n;
		reply_t fx;
		logic [63:0] k1, k2, k3, k4;
		k1 = 64'h0123_4567_89AB_CDEF;
		k2 = 64'hFEDC_BA98_7654_3210;
		k3 = 64'h5A5A_A5A5_0F0F_F0F0;
		k4 = 64'h8000_0000_0000_0001;

		for (i = 0; i < NSLOT; i++) begin
			map_live[i] = 0; map_tomb[i] = 0;
			map_key[i] = '0; map_val[i] = '0;
		end
		map_fill = 0;
		map_limit = LOAD_LIMIT_RST;
		for (i = 0; i < 32; i++) begin
			pool_key[i] = {$urandom, $urandom};
			// cluster start slots around the wrap point
			pool_hash[i] = {22'($urandom_range(0, 32'h3F_FFFF)),
				10'((1016 + $urandom_range(0, 15)) % NSLOT)};
		end

		// collisions at slot 10, tombstones, and wrap past the last slot
		dir_tab[0]  = '{CMD_GET,   k1, 32'd10, 64'd0, 1'b1, ST_MISS, 64'd0};
		dir_tab[1]  = '{CMD_DEL,   k1, 32'd10, 64'd0, 1'b1, ST_MISS, 64'd0};
		dir_tab[2]  = '{CMD_UNDEF, k1, 32'd10, 64'd5, 1'b1, ST_MISS, 64'd0};
		dir_tab[3]  = '{CMD_SET,   k1, 32'd10, 64'd11, 1'b1, ST_INSERTED, 64'd0};
		dir_tab[4]  = '{CMD_SET,   k1, 32'd10, 64'd22, 1'b1, ST_UPDATED, 64'd0};
		dir_tab[5]  = '{CMD_GET,   k1, 32'd10, 64'd0, 1'b1, ST_FOUND, 64'd22};
		dir_tab[6]  = '{CMD_SET,   k2, 32'd10, 64'd33, 1'b1, ST_INSERTED, 64'd0};
		dir_tab[7]  = '{CMD_DEL,   k1, 32'd10, 64'd0, 1'b1, ST_FOUND, 64'd22};
		dir_tab[8]  = '{CMD_GET,   k2, 32'd10, 64'd0, 1'b1, ST_FOUND, 64'd33};
		dir_tab[9]  = '{CMD_SET,   k3, 32'd10, 64'd44, 1'b1, ST_INSERTED, 64'd0};
		dir_tab[10] = '{CMD_DEL,   k3, 32'd10, 64'd0, 1'b1, ST_FOUND, 64'd44};
		// match past a tombstone must update, not reuse the tombstone
		dir_tab[11] = '{CMD_SET,   k2, 32'd10, 64'd55, 1'b1, ST_UPDATED, 64'd0};
		dir_tab[12] = '{CMD_GET,   k2, 32'd10, 64'd0, 1'b1, ST_FOUND, 64'd55};
		dir_tab[13] = '{CMD_SET, '1, '1, '1, 1'b1, ST_INSERTED, 64'd0};
		dir_tab[14] = '{CMD_SET, '0, 32'h0000_03FF, '0, 1'b1, ST_INSERTED, 64'd0};
		dir_tab[15] = '{CMD_GET, '0, '1, '0, 1'b1, ST_FOUND, 64'd0};
		dir_tab[16] = '{CMD_GET, '1, '1, '0, 1'b1, ST_FOUND, '1};
		dir_tab[17] = '{CMD_DEL, '1, '1, '0, 1'b1, ST_FOUND, '1};
		dir_tab[18] = '{CMD_SET, k4, 32'h0000_03FF, 64'hDEAD_BEEF_0000_1234, 1'b0, ST_MISS,
			64'd0};
		dir_tab[19] = '{CMD_UNDEF, '1, '1, '1, 1'b1, ST_MISS, 64'd0};
		dir_tab[20] = '{CMD_SET, 64'hA5A5_0000_FFFF_1111, 32'h1234_5678,
			64'h0F0F_0F0F_F0F0_F0F0, 1'b0, ST_MISS, 64'd0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// the core clears its flag memory first; the write waits on busy
		write_limit(LOAD_LIMIT_RST);
		for (i = 0; i < N_DIR; i++) begin
			fx.st = dir_tab[i].st;
			fx.rv = dir_tab[i].rv;
			send_op(dir_tab[i].c, dir_tab[i].k, dir_tab[i].h, dir_tab[i].v,
				dir_tab[i].typed, fx);
		end

		// tiny and zero limits: only tombstone reuse and updates succeed
		write_limit(11'd1);
		random_ops(30);
		write_limit(11'd0);
		random_ops(20);
		write_limit(11'd1023);
		random_ops(40);

		// fill every slot back to back, then overflow with fresh keys
		write_limit(11'd1024);
		idle_on = 1'b0;
		for (i = 0; i < NSLOT + 8; i++)
			send_pred(CMD_SET, {32'hC0DE_0000, i[31:0]}, i[31:0], {$urandom, $urandom});
		idle_on = 1'b1;
		send_pred(CMD_SET, {$urandom, $urandom}, $urandom, {$urandom, $urandom});
		send_pred(CMD_GET, {$urandom, $urandom}, $urandom, '0);
		random_ops(10);

		start <= 1'b0;
		wait_n = 0;
		while (pending_replies.size() != 0 && wait_n < 5000) begin
			@(posedge clk);
			wait_n++;
		end
		n_err += pending_replies.size();
		repeat (20) @(posedge clk);
		if (n_err == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lphm_pkg.sv
rtl/lphm_ctrl.sv
rtl/lphm_dp.sv
rtl/linear_probe_hash_map_core.sv
rtl/lphm_checker.sv
tb/tb.sv
